// ===== rtl/core/ray_box_slab_intersect_top_macros.svh =====
// Assertion macros shared by the ray-box intersection RTL.
`ifndef RAY_BOX_SLAB_INTERSECT_TOP_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RBSI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rbsi assertion failed");
`define RBSI_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rbsi reset assertion failed");
`else
`define RBSI_ASSERT(lbl, clk, rst_n, prop)
`define RBSI_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/rbsi_pkg.sv =====
// Types, constants and helpers for the ray-box slab intersection block.
package rbsi_pkg;

    localparam int QW          = 32;
    localparam int EPS_W       = 17;
    localparam int NUM_W       = 49;
    localparam int DIV_STAGES  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [QW-1:0] QMAX = 32'sh7fff_ffff;
    localparam logic signed [QW-1:0] QMIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [QW-1:0] origin_x;
        logic signed [QW-1:0] origin_y;
        logic signed [QW-1:0] origin_z;
        logic signed [QW-1:0] dir_x;
        logic signed [QW-1:0] dir_y;
        logic signed [QW-1:0] dir_z;
        logic signed [QW-1:0] box_min_x;
        logic signed [QW-1:0] box_min_y;
        logic signed [QW-1:0] box_min_z;
        logic signed [QW-1:0] box_max_x;
        logic signed [QW-1:0] box_max_y;
        logic signed [QW-1:0] box_max_z;
    } t_in;

    typedef struct packed {
        logic                 hit;
        logic signed [QW-1:0] hit_distance;
    } t_out;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             neg;
    } t_plane;

    typedef struct packed {
        logic          active;
        logic [QW-1:0] dm;
        t_plane        lo;
        t_plane        hi;
    } t_axis;

    typedef struct packed {
        logic            par_ok;
        t_axis [2:0]     axis;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Turn an unsigned quotient with overflow flag into a saturated signed value.
    function automatic logic signed [QW-1:0] resolve_q(logic [QW-2:0] q, logic ovf,
                                                     logic neg);
        logic [QW-1:0] ext;
        ext = {1'b0, q};
        if (ovf) begin
            resolve_q = neg ? QMIN : QMAX;
        end else begin
            resolve_q = neg ? -ext : ext;
        end
    endfunction

endpackage

// ===== rtl/core/rbsi_front.sv =====
// Front end: classify each axis as parallel or sloped and form divider operands.
module rbsi_front
    import rbsi_pkg::*;
(
    input  t_in              i_data,
    input  logic [EPS_W-1:0] i_eps,
    output t_work            o_work
);

    logic signed [QW-1:0] w_o  [3];
    logic signed [QW-1:0] w_d  [3];
    logic signed [QW-1:0] w_lo [3];
    logic signed [QW-1:0] w_hi [3];
    logic [2:0]           w_pass;

    assign w_o[0]  = i_data.origin_x;
    assign w_o[1]  = i_data.origin_y;
    assign w_o[2]  = i_data.origin_z;
    assign w_d[0]  = i_data.dir_x;
    assign w_d[1]  = i_data.dir_y;
    assign w_d[2]  = i_data.dir_z;
    assign w_lo[0] = i_data.box_min_x;
    assign w_lo[1] = i_data.box_min_y;
    assign w_lo[2] = i_data.box_min_z;
    assign w_hi[0] = i_data.box_max_x;
    assign w_hi[1] = i_data.box_max_y;
    assign w_hi[2] = i_data.box_max_z;

    genvar a;
    generate
        for (a = 0; a < 3; a++) begin : g_axis
            logic [QW-1:0]       w_mag;
            logic                w_par;
            logic                w_inside;
            logic signed [QW:0]  w_dlo;
            logic signed [QW:0]  w_dhi;
            logic [QW:0]         w_mlo;
            logic [QW:0]         w_mhi;

            assign w_mag    = w_d[a][QW-1] ? (~w_d[a] + 1'b1) : w_d[a];
            assign w_par    = (w_d[a] == '0) || (w_mag < {{(QW-EPS_W){1'b0}}, i_eps});
            assign w_inside = !((w_o[a] < w_lo[a]) || (w_o[a] > w_hi[a]));
            assign w_dlo    = {w_lo[a][QW-1], w_lo[a]} - {w_o[a][QW-1], w_o[a]};
            assign w_dhi    = {w_hi[a][QW-1], w_hi[a]} - {w_o[a][QW-1], w_o[a]};
            assign w_mlo    = w_dlo[QW] ? (~w_dlo + 1'b1) : w_dlo;
            assign w_mhi    = w_dhi[QW] ? (~w_dhi + 1'b1) : w_dhi;
            assign w_pass[a] = !w_par || w_inside;

            assign o_work.axis[a].active = !w_par;
            assign o_work.axis[a].dm     = w_mag;
            assign o_work.axis[a].lo.num = {w_mlo, 16'd0};
            assign o_work.axis[a].lo.neg = w_dlo[QW] ^ w_d[a][QW-1];
            assign o_work.axis[a].hi.num = {w_mhi, 16'd0};
            assign o_work.axis[a].hi.neg = w_dhi[QW] ^ w_d[a][QW-1];
        end
    endgenerate

    assign o_work.par_ok = &w_pass;

endmodule

// ===== rtl/core/rbsi_queue.sv =====
// Short register queue between the front end and the divider pipeline.
module rbsi_queue
    import rbsi_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_work  i_work,
    input  logic   i_pop,
    output t_work  o_work,
    output t_qstat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_work          r_slot [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_work       = r_slot[r_rp];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== rtl/core/rbsi_div.sv =====
// Pipelined restoring divider: the first stage sets the overflow flag, each later stage yields one quotient bit.
module rbsi_div
    import rbsi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [QW-1:0]    i_dm,
    input  logic             i_neg,
    output logic [QW-2:0]    o_q,
    output logic             o_ovf,
    output logic             o_neg
);

    logic [NUM_W-1:0] r_rem [DIV_STAGES];
    logic [QW-2:0]    r_q   [DIV_STAGES];
    logic [QW-1:0]    r_dm  [DIV_STAGES];
    logic             r_neg [DIV_STAGES];
    logic             r_ovf [DIV_STAGES];

    // First stage: quotient at or above 2^31 saturates.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_q[0]   <= '0;
            r_dm[0]  <= i_dm;
            r_neg[0] <= i_neg;
            r_ovf[0] <= {{(64-NUM_W){1'b0}}, i_num} >= {1'b0, i_dm, 31'd0};
        end
    end

    genvar s;
    generate
        for (s = 1; s < DIV_STAGES; s++) begin : g_stage
            localparam int B = DIV_STAGES - 1 - s;
            logic [63:0] w_sh;
            logic [63:0] w_rem;
            logic [63:0] w_diff;
            logic        w_ge;

            assign w_sh   = {32'd0, r_dm[s-1]} << B;
            assign w_rem  = {{(64-NUM_W){1'b0}}, r_rem[s-1]};
            assign w_ge   = w_rem >= w_sh;
            assign w_diff = w_rem - w_sh;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_ge ? w_diff[NUM_W-1:0] : r_rem[s-1];
                    r_q[s]   <= r_q[s-1] | ((QW-1)'(w_ge) << B);
                    r_dm[s]  <= r_dm[s-1];
                    r_neg[s] <= r_neg[s-1];
                    r_ovf[s] <= r_ovf[s-1];
                end
            end
        end
    endgenerate

    assign o_q   = r_q[DIV_STAGES-1];
    assign o_ovf = r_ovf[DIV_STAGES-1];
    assign o_neg = r_neg[DIV_STAGES-1];

endmodule

// ===== rtl/core/rbsi_back.sv =====
// Back end: six plane-distance dividers, interval narrowing and output register.
module rbsi_back
    import rbsi_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_work  i_work,
    input  t_qstat i_qstat,
    output logic   o_pop,
    output logic   o_valid,
    output t_out   o_data,
    input  logic   i_stall
);

    logic                 w_en;
    logic [QW-2:0]        w_q   [6];
    logic                 w_ovf [6];
    logic                 w_neg [6];
    logic signed [QW-1:0] w_t   [6];

    logic       r_v   [DIV_STAGES];
    logic       r_pok [DIV_STAGES];
    logic [2:0] r_act [DIV_STAGES];

    logic                 r_cv;
    logic                 r_cpok;
    logic [2:0]           r_cact;
    logic signed [QW-1:0] r_a [3];
    logic signed [QW-1:0] r_b [3];

    logic                 r_out_valid;
    t_out                 r_out;

    logic signed [QW-1:0] w_near;
    logic signed [QW-1:0] w_far;
    logic                 w_ok;

    // Hold the whole pipeline only while a finished result waits.
    assign w_en  = !(r_out_valid && i_stall);
    assign o_pop = w_en && !i_qstat.empty;

    genvar a;
    generate
        for (a = 0; a < 3; a++) begin : g_ax
            rbsi_div u_div_lo (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num (i_work.axis[a].lo.num),
                .i_dm  (i_work.axis[a].dm),
                .i_neg (i_work.axis[a].lo.neg),
                .o_q   (w_q[2*a]),
                .o_ovf (w_ovf[2*a]),
                .o_neg (w_neg[2*a])
            );
            rbsi_div u_div_hi (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num (i_work.axis[a].hi.num),
                .i_dm  (i_work.axis[a].dm),
                .i_neg (i_work.axis[a].hi.neg),
                .o_q   (w_q[2*a+1]),
                .o_ovf (w_ovf[2*a+1]),
                .o_neg (w_neg[2*a+1])
            );
            assign w_t[2*a]   = resolve_q(w_q[2*a], w_ovf[2*a], w_neg[2*a]);
            assign w_t[2*a+1] = resolve_q(w_q[2*a+1], w_ovf[2*a+1], w_neg[2*a+1]);

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_a[a] <= (w_t[2*a] < w_t[2*a+1]) ? w_t[2*a] : w_t[2*a+1];
                    r_b[a] <= (w_t[2*a] < w_t[2*a+1]) ? w_t[2*a+1] : w_t[2*a];
                end
            end
        end
    endgenerate

    // Sideband travels alongside the dividers.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pok[0] <= i_work.par_ok;
            r_act[0] <= {i_work.axis[2].active, i_work.axis[1].active,
                         i_work.axis[0].active};
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_pok[s] <= r_pok[s-1];
                r_act[s] <= r_act[s-1];
            end
            r_cpok <= r_pok[DIV_STAGES-1];
            r_cact <= r_act[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_v[s] <= 1'b0;
            end
            r_cv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= !i_qstat.empty;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_cv        <= r_v[DIV_STAGES-1];
            r_out_valid <= r_cv;
        end
    end

    always_comb begin
        w_near = QMIN;
        w_far  = QMAX;
        for (int k = 0; k < 3; k++) begin
            if (r_cact[k] && (r_a[k] > w_near)) begin
                w_near = r_a[k];
            end
            if (r_cact[k] && (r_b[k] < w_far)) begin
                w_far = r_b[k];
            end
        end
        w_ok = r_cpok && !(w_near > w_far) && !(w_far < 0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.hit          <= w_ok;
            r_out.hit_distance <= !w_ok ? '0 : ((w_near >= 0) ? w_near : w_far);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/core/ray_box_slab_intersect_top.sv =====
// Ray versus axis-aligned box intersection, slab method, Q16.16.
// Throughput: one ray-box pair per cycle unless the output stalls; set by the 32-stage divider pipelines.
// The six plane divisions run in parallel pipelined restoring dividers.
// Reset (synchronous, active low) empties the queue and pipeline; epsilon returns to 1.
`include "ray_box_slab_intersect_top_macros.svh"
module ray_box_slab_intersect_top
    import rbsi_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_in              i_data,
    output logic             o_stall,
    output logic             o_valid,
    output t_out             o_data,
    input  logic             i_stall,
    input  logic             i_cfg_we,
    input  logic [EPS_W-1:0] i_cfg_wdata
);

    logic [EPS_W-1:0] r_eps;
    t_work            w_front;
    t_work            w_head;
    t_qstat           w_qstat;
    logic             w_push;
    logic             w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_W'(1);
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    rbsi_front u_front (
        .i_data (i_data),
        .i_eps  (r_eps),
        .o_work (w_front)
    );

    assign o_stall = w_qstat.full;
    assign w_push  = i_valid && !w_qstat.full;

    rbsi_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_front),
        .i_pop   (w_pop),
        .o_work  (w_head),
        .o_stat  (w_qstat)
    );

    rbsi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    `RBSI_ASSERT(a_miss_zero, i_clk, i_rst_n, o_valid && !o_data.hit |-> o_data.hit_distance == 0)
    `RBSI_ASSERT(a_hit_ahead, i_clk, i_rst_n, o_valid && o_data.hit |-> !o_data.hit_distance[QW-1])
    `RBSI_ASSERT(a_pop_nonempty, i_clk, i_rst_n, w_pop |-> !w_qstat.empty)
    `RBSI_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && !o_stall)

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the ray-box slab intersection block.
module tb_top;
    import rbsi_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    t_in              i_data = '0;
    logic             o_stall;
    logic             o_valid;
    t_out             o_data;
    logic             i_stall = 1'b1;
    logic             i_cfg_we = 1'b0;
    logic [EPS_W-1:0] i_cfg_wdata = '0;

    localparam int LATENCY = 35;
    localparam longint CYCLE_LIMIT = 400000;

    logic [EPS_W-1:0] eps_model;
    t_out             expected_hits[$];
    int               mismatches = 0;
    int               hits_seen = 0;
    int               rays_sent = 0;
    int               results_seen = 0;
    longint           cycles = 0;
    int               hold_cycles = 0;
    bit               rx_random = 1'b0;
    int               rx_seen = 0;
    int               rx_wait = 0;
    int               rx_draw;

    ray_box_slab_intersect_top DUT (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint clamp_q(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_out predict_hit(t_in r);
        longint near_t, far_t, o, d, lo, hi, mag, t1, t2, a, b;
        bit     ok;
        t_out   res;
        near_t = -64'sd2147483648;
        far_t = 64'sd2147483647;
        ok = 1'b1;
        for (int ax = 0; ax < 3; ax++) begin
            case (ax)
                0: begin o = r.origin_x; d = r.dir_x; lo = r.box_min_x; hi = r.box_max_x; end
                1: begin o = r.origin_y; d = r.dir_y; lo = r.box_min_y; hi = r.box_max_y; end
                default: begin
                    o = r.origin_z; d = r.dir_z; lo = r.box_min_z; hi = r.box_max_z;
                end
            endcase
            mag = d < 0 ? -d : d;
            if (d == 0 || mag < longint'(eps_model)) begin
                if (o < lo || o > hi) ok = 1'b0;
            end else begin
                t1 = clamp_q(((lo - o) * 65536) / d);
                t2 = clamp_q(((hi - o) * 65536) / d);
                a = t1 < t2 ? t1 : t2;
                b = t1 < t2 ? t2 : t1;
                if (a > near_t) near_t = a;
                if (b < far_t) far_t = b;
            end
        end
        if (ok && near_t > far_t) ok = 1'b0;
        if (ok && far_t < 0) ok = 1'b0;
        res.hit = ok;
        res.hit_distance = ok ? (near_t >= 0 ? near_t[31:0] : far_t[31:0]) : '0;
        return res;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_data);
            end else begin
                exp_r = expected_hits.pop_front();
                if (o_data.hit) hits_seen++;
                if (o_data.hit !== exp_r.hit || o_data.hit_distance !== exp_r.hit_distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit=%0b dist=%h, got hit=%0b dist=%h",
                                 exp_r.hit, exp_r.hit_distance, o_data.hit,
                                 o_data.hit_distance);
                end
            end
        end
    end

    // Receiver stall: a long hold-off when requested, else a random wait drawn after each transfer when enabled
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (rx_random && results_seen != rx_seen) begin
            rx_seen <= results_seen;
            rx_draw = $urandom_range(0, 17);
            i_stall <= (rx_draw != 0);
            rx_wait <= (rx_draw > 0) ? rx_draw - 1 : 0;
        end else if (rx_wait > 0) begin
            i_stall <= 1'b1;
            rx_wait <= rx_wait - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_ray(t_in r, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= r;
        do @(posedge i_clk); while (o_stall);
        expected_hits.push_back(predict_hit(r));
        rays_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_epsilon(logic [EPS_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        eps_model = v;
    endtask

    function automatic logic [31:0] rand_q(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            2: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
            default: begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0;
                    3: return 32'h1;
                    4: return 32'hffff_ffff;
                    default: return 32'($signed($urandom_range(0, 4)) - 2);
                endcase
            end
        endcase
    endfunction

    function automatic t_in rand_ray();
        t_in r;
        int m;
        logic [31:0] a, b;
        m = $urandom_range(0, 9);
        m = m < 5 ? 1 : (m < 7 ? 0 : (m < 8 ? 2 : 3));
        r.origin_x = rand_q(m); r.origin_y = rand_q(m); r.origin_z = rand_q(m);
        r.dir_x = rand_q(m == 3 ? 3 : $urandom_range(0, 2));
        r.dir_y = rand_q(m == 3 ? 3 : $urandom_range(0, 2));
        r.dir_z = rand_q(m == 3 ? 3 : $urandom_range(0, 2));
        // mostly well-ordered boxes, some reversed
        a = rand_q(m); b = rand_q(m);
        if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
        r.box_min_x = a; r.box_max_x = b;
        a = rand_q(m); b = rand_q(m);
        if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
        r.box_min_y = a; r.box_max_y = b;
        a = rand_q(m); b = rand_q(m);
        if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
        r.box_min_z = a; r.box_max_z = b;
        return r;
    endfunction

    function automatic t_in make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                     int lo, int hi);
        t_in r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        r.box_min_x = lo; r.box_min_y = lo; r.box_min_z = lo;
        r.box_max_x = hi; r.box_max_y = hi; r.box_max_z = hi;
        return r;
    endfunction

    task automatic test_directed();
        localparam int ONE = 1 << 16;
        t_in r;
        send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, -ONE, ONE), 0);       // ahead hit
        send_ray(make_ray(5 * ONE, 0, 0, ONE, 0, 0, -ONE, ONE), 0);        // behind
        send_ray(make_ray(0, 0, 0, ONE, ONE, ONE, -ONE, ONE), 1);          // inside
        send_ray(make_ray(0, 0, 0, 0, 0, 0, -ONE, ONE), 0);                // all parallel
        send_ray(make_ray(0, 3 * ONE, 0, 0, 0, 0, -ONE, ONE), 0);          // parallel miss
        send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, ONE, -ONE), 2);       // reversed box
        send_ray(make_ray(32'h8000_0000, 0, 0, 1, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff), 0);
        send_ray(make_ray(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 1,
                          32'h8000_0000, 32'h7fff_ffff), 0);
        send_ray(make_ray(32'h7fff_ffff, 32'h8000_0000, 0, -1, 1, 32'hffff_ffff,
                          32'h8000_0000, 32'h7fff_ffff), 0);
        send_ray(make_ray(-ONE, -ONE, -ONE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          0, ONE), 3);
        send_ray(make_ray(-2 * ONE, 0, 0, ONE, ONE, 0, -ONE, ONE), 0);     // grazing
        r = '1;
        send_ray(r, 0);
        r = '0;
        send_ray(r, 0);
        for (int i = 0; i < 6; i++) send_ray(rand_ray(), 0);
        drain_results();
    endtask

    task automatic test_epsilon(logic [EPS_W-1:0] eps, int count);
        write_epsilon(eps);
        rx_random = 1'b1;
        for (int i = 0; i < count; i++)
            send_ray(rand_ray(), $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17));
        drain_results();
    endtask

    task automatic test_back_pressure();
        hold_cycles = 300;
        for (int i = 0; i < 80; i++) send_ray(rand_ray(), 0);
        drain_results();
    endtask

    task automatic test_streaming();
        rx_random = 1'b0;
        for (int i = 0; i < 300; i++) send_ray(rand_ray(), 0);
        drain_results();
    endtask

    initial begin
        eps_model = 17'd1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_epsilon(17'd0, 250);
        test_epsilon(17'h1_0000, 300);
        test_epsilon(17'h1_ffff, 200);
        test_epsilon(17'd300, 350);
        test_back_pressure();
        test_streaming();
        test_epsilon(17'd1, 400);
        $display("sent %0d rays across five epsilon settings, %0d results, %0d hits",
                 rays_sent, results_seen, hits_seen);
        $display("included long output hold-off and back-to-back streaming");
        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_hits.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rbsi_pkg.sv
rtl/core/rbsi_front.sv
rtl/core/rbsi_queue.sv
rtl/core/rbsi_div.sv
rtl/core/rbsi_back.sv
rtl/core/ray_box_slab_intersect_top.sv
bench/tb_top.sv
